### rtl/etf_pkg.sv
// shared types, constants and saturation helper for the escape-time fractal pixel unit
// no dependencies
`timescale 1ns / 1ps

package etf_pkg;

   // number format of z and c inside the iteration
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 26;

   // width of the external coordinate fields and config data
   localparam int IO_BITS = 32;
   localparam int ITER_BITS = 24;
   localparam int CSR_IDX_BITS = 4;

   // product and magnitude widths
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int LIM_EXP = 2 * FRAC_BITS + 4;
   localparam int SUM_BITS = (PROD_BITS + 1 > LIM_EXP + 1) ? PROD_BITS + 1 : LIM_EXP + 1;
   localparam int EXT_BITS = SUM_BITS + 2;

   // bailout limit: |z|^2 > 16 in the squared format
   localparam logic [SUM_BITS-1:0] BAIL_LIMIT = SUM_BITS'(1) << LIM_EXP;

   localparam logic [ITER_BITS-1:0] MAX_ITER_RESET = ITER_BITS'(256);

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [EXT_BITS-1:0] ext_type;
   typedef logic signed [IO_BITS-1:0] io_type;
   typedef logic [ITER_BITS-1:0] iter_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MAX_ITER   = 4'd0,
      CSR_JULIA_MODE = 4'd1,
      CSR_JULIA_RE   = 4'd2,
      CSR_JULIA_IM   = 4'd3
   } csr_idx_type;

   typedef struct packed {
      iter_type max_iter;
      logic     julia_mode;
      io_type   julia_re;
      io_type   julia_im;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic sum;
      logic step;
      logic mark_esc;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic iter_done;
      logic outside;
      logic out_free;
   } stat_type;

   // clamp a signed value to a signed range of 'bits' bits
   function automatic ext_type sat_bits(input ext_type x, input int bits);
      ext_type hi;
      ext_type lo;
      hi = (ext_type'(1) <<< (bits - 1)) - ext_type'(1);
      lo = -hi - ext_type'(1);
      if (x > hi) begin
         return hi;
      end else if (x < lo) begin
         return lo;
      end
      return x;
   endfunction

endpackage

### rtl/escape_time_fractal_pixel_unit.sv
// escape-time fractal pixel unit: mandelbrot or julia iteration of one pixel per beat
// each iteration steps through multiply, sum and evaluate; the result is loaded into the
// output register once the cap of max_iter steps is reached or z escapes
// the next pixel can be taken in the cycle after a result is loaded, and any output stall
// holds that load back; the one set of three multipliers serves every iteration
// reset: synchronous, active high; clears sequencer and output valid, config to defaults
`timescale 1ns / 1ps

module escape_time_fractal_pixel_unit (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  etf_pkg::io_type       req_pixel_re,
   input  etf_pkg::io_type       req_pixel_im,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output etf_pkg::iter_type     rsp_iter_value,
   output logic                  rsp_escaped,
   output etf_pkg::io_type       rsp_final_re,
   output etf_pkg::io_type       rsp_final_im,
   // config write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  etf_pkg::csr_idx_type  csr_index,
   input  logic [31:0]           csr_wdata
);
   import etf_pkg::*;

   // config registers
   iter_type max_iter_ff;
   logic     julia_mode_ff;
   io_type   julia_re_ff;
   io_type   julia_im_ff;
   cfg_type  cfg;

   // controller / datapath link
   cmd_type  cmd;
   stat_type stat;

   // writes are always taken; c is sampled at pixel load and the cap is read live,
   // so writes belong between pixels
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff   <= MAX_ITER_RESET;
         julia_mode_ff <= 1'b0;
         julia_re_ff   <= '0;
         julia_im_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_ITER:   max_iter_ff   <= csr_wdata[ITER_BITS-1:0];
            CSR_JULIA_MODE: julia_mode_ff <= csr_wdata[0];
            CSR_JULIA_RE:   julia_re_ff   <= io_type'(csr_wdata);
            CSR_JULIA_IM:   julia_im_ff   <= io_type'(csr_wdata);
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   assign cfg.max_iter   = max_iter_ff;
   assign cfg.julia_mode = julia_mode_ff;
   assign cfg.julia_re   = julia_re_ff;
   assign cfg.julia_im   = julia_im_ff;

   // sequencer: idle, multiply, sum, evaluate, finish
   etf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // z state, products, bailout test and the output register
   etf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .pixel_re       (req_pixel_re),
      .pixel_im       (req_pixel_im),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_iter_value (rsp_iter_value),
      .rsp_escaped    (rsp_escaped),
      .rsp_final_re   (rsp_final_re),
      .rsp_final_im   (rsp_final_im)
   );

endmodule

### rtl/etf_ctrl.sv
// sequencing state machine for the escape-time fractal pixel unit
// depends on etf_pkg for command and status structs
`timescale 1ns / 1ps

module etf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  etf_pkg::stat_type stat,
   output etf_pkg::cmd_type  cmd
);
   import etf_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_SUM  = 5'b00100,
      S_EVAL = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (stat.iter_done) begin
               state_in = S_FIN;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (stat.outside) begin
               cmd.mark_esc = 1'b1;
               state_in     = S_FIN;
            end else begin
               cmd.step = 1'b1;
               state_in = S_MUL;
            end
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/etf_datapath.sv
// z registers, squaring multipliers, bailout test, update and result register
// depends on etf_pkg for formats, structs and saturation
`timescale 1ns / 1ps

module etf_datapath (
   input  logic              clock,
   input  logic              reset,
   input  etf_pkg::cfg_type  cfg,
   input  etf_pkg::io_type   pixel_re,
   input  etf_pkg::io_type   pixel_im,
   input  etf_pkg::cmd_type  cmd,
   output etf_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output etf_pkg::iter_type rsp_iter_value,
   output logic              rsp_escaped,
   output etf_pkg::io_type   rsp_final_re,
   output etf_pkg::io_type   rsp_final_im
);
   import etf_pkg::*;

   word_type zr_ff, zi_ff, cr_ff, ci_ff;
   word_type zr_in, zi_in, cr_in, ci_in;
   word_type ld_re, ld_im, jul_re, jul_im;
   iter_type m_ff;
   logic     esc_ff;

   prod_type rr_ff, ii_ff, ri_ff;
   logic [SUM_BITS-1:0]       sum_ff;
   logic signed [PROD_BITS:0] diff_ff;

   ext_type nr_full, ni_full, nr_sat, ni_sat;
   ext_type fr_sat, fi_sat;

   logic     rsp_valid_ff, rsp_valid_in;
   iter_type iter_ff, iter_in;
   logic     escaped_ff;
   io_type   final_re_ff, final_im_ff, final_re_in, final_im_in;

   // input and julia constant into the working format
   assign ld_re  = WORD_BITS'(sat_bits(ext_type'(pixel_re), WORD_BITS));
   assign ld_im  = WORD_BITS'(sat_bits(ext_type'(pixel_im), WORD_BITS));
   assign jul_re = WORD_BITS'(sat_bits(ext_type'(cfg.julia_re), WORD_BITS));
   assign jul_im = WORD_BITS'(sat_bits(ext_type'(cfg.julia_im), WORD_BITS));
   assign cr_in  = cfg.julia_mode ? jul_re : ld_re;
   assign ci_in  = cfg.julia_mode ? jul_im : ld_im;

   // next z from the registered difference and cross product
   assign nr_full = ext_type'(diff_ff >>> FRAC_BITS) + ext_type'(cr_ff);
   assign ni_full = ext_type'(ri_ff >>> (FRAC_BITS - 1)) + ext_type'(ci_ff);
   assign nr_sat  = sat_bits(nr_full, WORD_BITS);
   assign ni_sat  = sat_bits(ni_full, WORD_BITS);
   assign zr_in   = cmd.load ? ld_re : WORD_BITS'(nr_sat);
   assign zi_in   = cmd.load ? ld_im : WORD_BITS'(ni_sat);

   assign stat.iter_done = (m_ff == cfg.max_iter);
   assign stat.outside   = (sum_ff > BAIL_LIMIT);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load || cmd.step) begin
         zr_ff <= zr_in;
         zi_ff <= zi_in;
      end
      if (cmd.load) begin
         cr_ff <= cr_in;
         ci_ff <= ci_in;
         m_ff  <= '0;
      end else if (cmd.step) begin
         m_ff <= m_ff + ITER_BITS'(1);
      end
      if (cmd.load) begin
         esc_ff <= 1'b0;
      end else if (cmd.mark_esc) begin
         esc_ff <= 1'b1;
      end
      if (cmd.mul) begin
         rr_ff <= prod_type'(zr_ff) * prod_type'(zr_ff);
         ii_ff <= prod_type'(zi_ff) * prod_type'(zi_ff);
         ri_ff <= prod_type'(zr_ff) * prod_type'(zi_ff);
      end
      if (cmd.sum) begin
         sum_ff  <= SUM_BITS'($unsigned(rr_ff)) + SUM_BITS'($unsigned(ii_ff));
         diff_ff <= (PROD_BITS + 1)'(rr_ff) - (PROD_BITS + 1)'(ii_ff);
      end
   end

   // result formatting
   assign fr_sat = sat_bits(ext_type'(zr_ff), IO_BITS);
   assign fi_sat = sat_bits(ext_type'(zi_ff), IO_BITS);

   always_comb begin
      if (esc_ff) begin
         iter_in     = (m_ff == '0) ? cfg.max_iter : m_ff;
         final_re_in = IO_BITS'(fr_sat);
         final_im_in = IO_BITS'(fi_sat);
      end else begin
         iter_in     = cfg.max_iter;
         final_re_in = '0;
         final_im_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         iter_ff     <= iter_in;
         escaped_ff  <= esc_ff;
         final_re_ff <= final_re_in;
         final_im_ff <= final_im_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iter_value = iter_ff;
   assign rsp_escaped    = escaped_ff;
   assign rsp_final_re   = final_re_ff;
   assign rsp_final_im   = final_im_ff;

endmodule

### dv/tb.sv
// self-checking testbench for escape_time_fractal_pixel_unit: mandelbrot and julia pixels
// checked against an escape-time predictor built on 128-bit signed arithmetic
// depends on rtl/etf_pkg.sv and rtl/escape_time_fractal_pixel_unit.sv
`timescale 1ns / 1ps

module tb;
   import etf_pkg::*;

   // long receiver hold, settle time after a phase, overall watchdog
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT = 4000000;

   // index with no register behind it, chosen so that csr_index bit 2 gets exercised
   localparam csr_idx_type CSR_UNMAPPED = csr_idx_type'(4'd13);

   // pixels far enough out (|re| >= 2.25) that mandelbrot escapes in a few steps
   localparam int unsigned FAR_EDGE = 9 << (FRAC_BITS - 2);

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      io_type re;
      io_type im;
   } pixel_beat_type;

   typedef struct packed {
      iter_type iter_value;
      logic     escaped;
      io_type   final_re;
      io_type   final_im;
   } pixel_result_type;

   // where random coordinates come from
   typedef enum int {PIX_NEAR, PIX_WIDE, PIX_FAR, PIX_MIXED} coord_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   io_type      req_pixel_re = '0;
   io_type      req_pixel_im = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   iter_type    rsp_iter_value;
   logic        rsp_escaped;
   io_type      rsp_final_re;
   io_type      rsp_final_im;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = CSR_MAX_ITER;
   logic [31:0] csr_wdata = '0;

   // testbench copy of the configuration, updated on each csr handshake
   iter_type cfg_max_iter = MAX_ITER_RESET;
   logic     cfg_julia_mode = 1'b0;
   io_type   cfg_julia_re = '0;
   io_type   cfg_julia_im = '0;

   pixel_beat_type   pixel_queue[$];   // pixels waiting to be offered
   pixel_result_type pixel_expect[$];  // predicted results, oldest first
   pixel_beat_type   next_pixel;
   pixel_result_type head;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit req_taken = 1'b0;
   bit hold_go = 1'b0;
   int hold_left = 0;
   int error_count = 0;
   int cycle_count = 0;

   escape_time_fractal_pixel_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_re   (req_pixel_re),
      .req_pixel_im   (req_pixel_im),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_iter_value (rsp_iter_value),
      .rsp_escaped    (rsp_escaped),
      .rsp_final_re   (rsp_final_re),
      .rsp_final_im   (rsp_final_im),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // clamp a wide signed value into a signed range of the given width
   function automatic wide_type clamp_signed(wide_type x, int bits);
      wide_type top;
      wide_type bottom;
      top = (wide_type'(1) <<< (bits - 1)) - wide_type'(1);
      bottom = -top - wide_type'(1);
      if (x > top) begin
         return top;
      end
      if (x < bottom) begin
         return bottom;
      end
      return x;
   endfunction

   // escape-time count of one pixel under the current configuration
   function automatic pixel_result_type escape_time(io_type px_re, io_type px_im);
      wide_type zr, zi, cr, ci, rr, ii, ri, bail;
      int unsigned n;
      pixel_result_type r;
      r = '0;
      zr = clamp_signed(wide_type'(px_re), WORD_BITS);
      zi = clamp_signed(wide_type'(px_im), WORD_BITS);
      if (cfg_julia_mode) begin
         cr = clamp_signed(wide_type'(cfg_julia_re), WORD_BITS);
         ci = clamp_signed(wide_type'(cfg_julia_im), WORD_BITS);
      end else begin
         cr = zr;
         ci = zi;
      end
      // bailout |z|^2 > 16, compared exactly in the squared format
      bail = wide_type'(16) <<< (2 * FRAC_BITS);
      n = 0;
      while (n < cfg_max_iter && !r.escaped) begin
         if (zr * zr + zi * zi > bail) begin
            r.escaped = 1'b1;
         end else begin
            rr = zr * zr;
            ii = zi * zi;
            ri = zr * zi;
            // one floor per component, 2*re*im folded into the shift
            zr = clamp_signed(((rr - ii) >>> FRAC_BITS) + cr, WORD_BITS);
            zi = clamp_signed((ri >>> (FRAC_BITS - 1)) + ci, WORD_BITS);
            n++;
         end
      end
      // a pixel that starts outside reports the cap, not zero
      r.iter_value = (r.escaped && n != 0) ? iter_type'(n) : cfg_max_iter;
      if (r.escaped) begin
         r.final_re = io_type'(clamp_signed(zr, IO_BITS));
         r.final_im = io_type'(clamp_signed(zi, IO_BITS));
      end
      return r;
   endfunction

   function automatic io_type fx(real v);
      return io_type'($rtoi(v * (2.0 ** FRAC_BITS)));
   endfunction

   function automatic pixel_beat_type pick_pixel(coord_style_type style);
      pixel_beat_type p;
      io_type mag;
      coord_style_type s;
      s = style;
      if (s == PIX_MIXED) begin
         s = ($urandom_range(9) < 8) ? PIX_NEAR : PIX_WIDE;
      end
      case (s)
         PIX_NEAR: begin
            // spans of +-4 down to +-0.5, where the interesting orbits live
            p.re = io_type'($signed($urandom) >>> $urandom_range(6, 3));
            p.im = io_type'($signed($urandom) >>> $urandom_range(6, 3));
         end
         PIX_FAR: begin
            mag = io_type'($urandom_range(32'h7fff_ffff, FAR_EDGE));
            p.re = $urandom_range(1) ? -mag : mag;
            p.im = io_type'($urandom);
         end
         default: begin
            p.re = io_type'($urandom);
            p.im = io_type'($urandom);
         end
      endcase
      return p;
   endfunction

   function automatic void queue_pixel(io_type re, io_type im);
      pixel_queue.push_back('{re, im});
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
               what, cycle_count, got, want);
   endtask

   // one csr beat; the local config copy follows the handshake
   task automatic write_csr(csr_idx_type idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MAX_ITER:   cfg_max_iter = data[ITER_BITS-1:0];
         CSR_JULIA_MODE: cfg_julia_mode = data[0];
         CSR_JULIA_RE:   cfg_julia_re = data;
         CSR_JULIA_IM:   cfg_julia_im = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // waits until every queued pixel is sent and every predicted result has come back
   task automatic wait_idle();
      @(posedge clock);
      while (pixel_queue.size() != 0 || req_valid || pixel_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int count, int idle_pct, int stall_pct, coord_style_type style,
                            bit long_hold);
      @(posedge clock);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) pixel_queue.push_back(pick_pixel(style));
      if (long_hold) begin
         // receiver blocks while the sender keeps offering, so the unit backs up
         hold_go = 1'b1;
         while (hold_left == 0) @(posedge clock);
         hold_go = 1'b0;
      end
      wait_idle();
   endtask

   // pixel driver: a new beat goes out only after the current one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_pixel = pixel_queue.pop_front();
            req_valid <= 1'b1;
            req_pixel_re <= next_pixel.re;
            req_pixel_im <= next_pixel.im;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure, plus the long hold counted down here
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_go) begin
         hold_left <= HOLD_CYCLES;
      end
      rsp_stall <= !reset && (hold_left != 0 || hold_go ||
                              $urandom_range(99) < recv_stall_pct);
   end

   // monitor: check accepted results first, then predict for accepted pixels
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pixel_expect.size() == 0) begin
               report_mismatch("result with nothing expected", 64'(rsp_iter_value), 64'(0));
            end else begin
               head = pixel_expect.pop_front();
               if (rsp_iter_value !== head.iter_value) begin
                  report_mismatch("iter_value", 64'(rsp_iter_value), 64'(head.iter_value));
               end
               if (rsp_escaped !== head.escaped) begin
                  report_mismatch("escaped", 64'(rsp_escaped), 64'(head.escaped));
               end
               if (rsp_final_re !== head.final_re) begin
                  report_mismatch("final_re", 64'(rsp_final_re), 64'(head.final_re));
               end
               if (rsp_final_im !== head.final_im) begin
                  report_mismatch("final_im", 64'(rsp_final_im), 64'(head.final_im));
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            pixel_expect.push_back(escape_time(req_pixel_re, req_pixel_im));
         end
      end
   end

   // watchdog, far above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: mandelbrot, cap 256
      queue_pixel(fx(0.0), fx(0.0));          // origin never leaves
      queue_pixel(fx(-2.0), fx(0.0));         // tip of the set, stays at 2
      queue_pixel(fx(0.25), fx(0.0));         // cusp, slow crawl, stays in
      queue_pixel(fx(1.0), fx(1.0));          // escapes on the second step
      queue_pixel(fx(4.0), fx(0.0));          // |z|^2 exactly 16 is still inside
      queue_pixel(fx(0.0), fx(-4.0));
      queue_pixel(fx(-0.75), fx(0.1));
      queue_pixel(fx(3.0), fx(3.0));          // outside from the start
      queue_pixel(32'sh7fff_ffff, 32'sh7fff_ffff);
      queue_pixel(32'sh8000_0000, 32'sh8000_0000);
      queue_pixel(32'sh8000_0000, 32'sh7fff_ffff);
      queue_pixel(32'sh0000_0000, 32'sh8000_0000);
      queue_pixel(32'sh0000_0001, -32'sh0000_0001);
      wait_idle();

      // cap of one; bits above the count field are dropped
      write_csr(CSR_MAX_ITER, 32'hff00_0001);
      queue_pixel(fx(0.0), fx(0.0));
      queue_pixel(fx(1.0), fx(1.0));
      queue_pixel(fx(4.5), fx(0.0));
      wait_idle();

      // zero cap
      write_csr(CSR_MAX_ITER, 32'd0);
      queue_pixel(fx(0.0), fx(0.0));
      queue_pixel(fx(5.0), fx(5.0));
      wait_idle();

      // largest cap, only with pixels that escape quickly
      write_csr(CSR_MAX_ITER, 32'h00ff_ffff);
      queue_pixel(fx(1.0), fx(1.0));
      queue_pixel(fx(-3.0), fx(0.5));
      wait_idle();

      // julia with the constant at the top of the range: iterates saturate
      write_csr(CSR_JULIA_RE, 32'h7fff_ffff);
      write_csr(CSR_JULIA_IM, 32'h7fff_ffff);
      write_csr(CSR_JULIA_MODE, 32'd1);
      write_csr(CSR_MAX_ITER, 32'd256);
      queue_pixel(fx(4.0), fx(0.0));
      queue_pixel(fx(0.0), fx(0.0));
      queue_pixel(fx(-4.0), fx(0.0));
      wait_idle();
      write_csr(CSR_JULIA_RE, 32'h8000_0000);
      write_csr(CSR_JULIA_IM, 32'h8000_0000);
      queue_pixel(fx(0.0), fx(0.0));
      wait_idle();

      // mandelbrot, steady flow with one long receiver hold
      write_csr(CSR_JULIA_MODE, 32'd0);
      write_csr(CSR_MAX_ITER, 32'd64);
      run_phase(250, 0, 0, PIX_MIXED, 1'b1);

      // sparse sender
      write_csr(CSR_MAX_ITER, $urandom_range(128, 16));
      run_phase(250, 88, 0, PIX_MIXED, 1'b0);

      // heavy back-pressure
      write_csr(CSR_MAX_ITER, 32'd48);
      run_phase(250, 0, 88, PIX_MIXED, 1'b0);

      // julia with a random constant near the origin, light gaps on both sides
      write_csr(CSR_JULIA_RE, $signed($urandom) >>> 5);
      write_csr(CSR_JULIA_IM, $signed($urandom) >>> 5);
      write_csr(CSR_JULIA_MODE, 32'd1);
      write_csr(CSR_MAX_ITER, 32'd96);
      run_phase(250, 6, 6, PIX_MIXED, 1'b0);

      // a classic connected julia set
      write_csr(CSR_JULIA_RE, fx(-0.8));
      write_csr(CSR_JULIA_IM, fx(0.156));
      write_csr(CSR_MAX_ITER, 32'd100);
      run_phase(200, 0, 0, PIX_NEAR, 1'b0);

      // largest cap again, far-out mandelbrot pixels only
      write_csr(CSR_JULIA_MODE, 32'd0);
      write_csr(CSR_MAX_ITER, 32'h00ff_ffff);
      run_phase(100, 6, 6, PIX_FAR, 1'b0);

      // tiny caps with julia constants anywhere in the word
      for (int k = 0; k < 5; k++) begin
         write_csr(CSR_MAX_ITER, $urandom_range(4, 1));
         write_csr(CSR_JULIA_RE, $urandom);
         write_csr(CSR_JULIA_IM, $urandom);
         write_csr(CSR_JULIA_MODE, 32'd1);
         run_phase(30, (k % 2) ? 88 : 0, (k % 2) ? 0 : 88, PIX_MIXED, 1'b0);
      end

      // a write to a hole in the map must change nothing; then zero cap
      write_csr(CSR_UNMAPPED, $urandom);
      write_csr(CSR_MAX_ITER, 32'd0);
      run_phase(50, 88, 0, PIX_MIXED, 1'b0);

      // mode takes bit 0 only: 2 selects mandelbrot
      write_csr(CSR_JULIA_MODE, 32'd2);
      write_csr(CSR_MAX_ITER, 32'd200);
      run_phase(150, 6, 6, PIX_NEAR, 1'b0);

      if (pixel_expect.size() != 0) begin
         report_mismatch("results never returned", 64'(pixel_expect.size()), 64'(0));
      end
      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/etf_pkg.sv
rtl/etf_ctrl.sv
rtl/etf_datapath.sv
rtl/escape_time_fractal_pixel_unit.sv
dv/tb.sv
